FILE: rtl/core/lwbc_pkg.sv
package lwbc_pkg;

  localparam int MAX_SLOTS_DEF  = 64;
  localparam int STAMP_BITS_DEF = 32;
  localparam int CLUSTER_W      = 28;
  localparam int SLOT_W         = 6;
  localparam int CAP_W          = 7;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // request as it travels from front to back
  typedef struct packed {
    logic                 is_write;
    logic [CLUSTER_W-1:0] cluster;
  } req_t;

  // result fields of one item
  typedef struct packed {
    logic                 hit;
    logic                 slot_valid;
    logic [SLOT_W-1:0]    slot;
    logic                 writeback_needed;
    logic [CLUSTER_W-1:0] evicted_cluster;
  } rsp_t;

endpackage

FILE: rtl/core/lwbc_if.sv
interface lwbc_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [lwbc_pkg::CLUSTER_W-1:0] cluster_number;
  modport source (output valid, req_type, cluster_number, input ready);
  modport sink   (input valid, req_type, cluster_number, output ready);
endinterface

interface lwbc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          slot_valid;
  logic [lwbc_pkg::SLOT_W-1:0]    slot;
  logic                          writeback_needed;
  logic [lwbc_pkg::CLUSTER_W-1:0] evicted_cluster;
  modport source (output valid, hit, slot_valid, slot, writeback_needed, evicted_cluster,
                  input ready);
  modport sink   (input valid, hit, slot_valid, slot, writeback_needed, evicted_cluster,
                  output ready);
endinterface

FILE: rtl/core/lwbc_front.sv
module lwbc_front (
  input  logic           clk,
  input  logic           rst,
  lwbc_req_if.sink       req,
  output logic           q_valid,
  input  logic           q_ready,
  output lwbc_pkg::req_t q_data
);

  // two-entry queue between front and back
  lwbc_pkg::req_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  logic push;
  logic pop;

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign pop       = q_valid && q_ready;
  assign q_valid   = (count != 2'd0);
  assign q_data    = mem[rd_ptr];

  // store items, advance pointers
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr].is_write <= req.req_type;
      mem[wr_ptr].cluster  <= req.cluster_number;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !pop) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1)) else $error("count step");
`endif

endmodule

FILE: rtl/core/lwbc_back.sv
module lwbc_back #(
  parameter int MAX_SLOTS  = lwbc_pkg::MAX_SLOTS_DEF,
  parameter int STAMP_BITS = lwbc_pkg::STAMP_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lwbc_pkg::CAP_W-1:0]  cap_reg,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  lwbc_pkg::req_t              q_data,
  lwbc_rsp_if.source                  rsp
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MATCH, S_LRU, S_UPDATE, S_OUT
  } state_t;

  state_t state;

  // tag and stamp memories, dirty bits in flops
  logic [lwbc_pkg::CLUSTER_W-1:0] tag_mem   [MAX_SLOTS];
  logic [STAMP_BITS-1:0]          stamp_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]           dirty;

  logic [CNT_W-1:0]               entry_count;
  logic [STAMP_BITS-1:0]          counter;
  lwbc_pkg::req_t                 cur;
  logic [CNT_W-1:0]               cap_eff;
  logic [CNT_W-1:0]               scan;
  logic                           rd_pend;
  logic [IDX_W-1:0]               rd_idx;
  logic [lwbc_pkg::CLUSTER_W-1:0] tag_rd;
  logic [STAMP_BITS-1:0]          stamp_rd;
  logic [IDX_W-1:0]               best;
  logic [STAMP_BITS-1:0]          best_age;
  logic                           found;
  logic [IDX_W-1:0]               sel;
  logic                           do_write;
  logic [STAMP_BITS-1:0]          age_rd;
  lwbc_pkg::rsp_t                 res;
  logic [lwbc_pkg::CLUSTER_W-1:0] tag_mem_victim;
  logic [lwbc_pkg::CLUSTER_W-1:0] best_tag;

  // saturate configured capacity
  always_comb begin
    if ({{(32-lwbc_pkg::CAP_W){1'b0}}, cap_reg} > MAX_SLOTS) cap_eff = CNT_W'(MAX_SLOTS);
    else cap_eff = CNT_W'(cap_reg);
  end

  assign age_rd  = counter - stamp_rd;
  assign q_ready = (state == S_IDLE);
  assign rsp.valid            = (state == S_OUT);
  assign rsp.hit              = res.hit;
  assign rsp.slot_valid       = res.slot_valid;
  assign rsp.slot             = res.slot;
  assign rsp.writeback_needed = res.writeback_needed;
  assign rsp.evicted_cluster  = res.evicted_cluster;

  // registered memory reads
  always_ff @(posedge clk) begin
    tag_rd   <= tag_mem[rd_idx];
    stamp_rd <= stamp_mem[rd_idx];
    if (do_write) begin
      tag_mem[sel]   <= cur.cluster;
      stamp_mem[sel] <= counter;
    end
  end

  assign do_write = (state == S_UPDATE) && (found || cur.is_write);

  // sequence match scan, LRU scan, update, output
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      dirty       <= '0;
      entry_count <= '0;
      counter     <= '0;
      rd_pend     <= 1'b0;
      rd_idx      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur     <= q_data;
            res     <= '0;
            found   <= 1'b0;
            scan    <= '0;
            rd_idx  <= '0;
            rd_pend <= 1'b0;
            if (cap_eff == '0) begin
              state <= S_OUT;
            end else begin
              counter <= counter + 1'b1;
              state   <= S_MATCH;
            end
          end
        end
        S_MATCH: begin
          // one entry per cycle; rd_pend marks tag_rd as data of scan-1
          if (rd_pend && tag_rd == cur.cluster) begin
            found <= 1'b1;
            sel   <= IDX_W'(scan - 1'b1);
            state <= S_UPDATE;
          end else if (scan >= entry_count) begin
            if (cur.is_write && entry_count >= cap_eff) begin
              scan    <= '0;
              rd_idx  <= '0;
              rd_pend <= 1'b0;
              state   <= S_LRU;
            end else begin
              sel   <= IDX_W'(entry_count);
              state <= S_UPDATE;
            end
          end else begin
            scan    <= scan + 1'b1;
            rd_idx  <= IDX_W'(scan + 1'b1);
            rd_pend <= 1'b1;
          end
        end
        S_LRU: begin
          if (rd_pend && (scan == CNT_W'(1) || age_rd > best_age)) begin
            best     <= IDX_W'(scan - 1'b1);
            best_age <= age_rd;
          end
          if (scan >= entry_count && rd_pend) begin
            state <= S_UPDATE;
          end else begin
            scan    <= scan + 1'b1;
            rd_idx  <= IDX_W'(scan + 1'b1);
            rd_pend <= 1'b1;
          end
          if (scan >= entry_count && rd_pend) begin
            if (scan == CNT_W'(1) || age_rd > best_age) sel <= IDX_W'(scan - 1'b1);
            else sel <= best;
          end
        end
        S_UPDATE: begin
          // victim tag for write-back comes from best_tag, captured during the LRU scan
          if (found) begin
            res.hit        <= 1'b1;
            res.slot_valid <= 1'b1;
            res.slot       <= lwbc_pkg::SLOT_W'(sel);
            if (cur.is_write) dirty[sel] <= 1'b1;
          end else if (cur.is_write) begin
            res.slot_valid <= 1'b1;
            res.slot       <= lwbc_pkg::SLOT_W'(sel);
            if (entry_count >= cap_eff) begin
              res.writeback_needed <= dirty[sel];
              if (dirty[sel]) res.evicted_cluster <= tag_mem_victim;
            end else begin
              entry_count <= entry_count + 1'b1;
            end
            dirty[sel] <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // victim tag captured during the LRU scan
  always_ff @(posedge clk) begin
    if (state == S_LRU && rd_pend && (scan == CNT_W'(1) || age_rd > best_age))
      best_tag <= tag_rd;
  end
  assign tag_mem_victim = best_tag;

`ifndef NO_ASSERTIONS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_SLOTS)) else $error("entry count overflow");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !q_ready) else $error("accept while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("result dropped");
`endif

endmodule

FILE: rtl/core/lru_writeback_block_cache_tags_core.sv
// Tag and LRU policy engine of a fully associative write-back cluster cache.
// Channel req carries req_type and cluster_number; channel rsp carries hit,
// slot_valid, slot, writeback_needed and evicted_cluster, one item per request.
// Both use valid/ready; an item moves when both are high at a clock edge.
// cfg_we/cfg_data write capacity_blocks (0 disables the cache, values above
// MAX_SLOTS saturate). Write it only while the block is idle.
// A disabled request goes straight to the result. Otherwise the back end scans
// the tag memory one entry per cycle for a match, and a write miss into a full
// table scans once more for the oldest stamp. The back end takes the next item
// only after the result of the last one has been accepted. The single read
// port of the tag/stamp memory sets the scan rate.
// A two-entry queue in the front takes requests until full while the back works
// or while a result waits for rsp.ready; the result is held until taken.
// Reset (rst, synchronous) clears entry count, dirty bits, access counter and
// capacity; no memory clearing pass is needed.
module lru_writeback_block_cache_tags_core #(
  parameter int MAX_SLOTS  = lwbc_pkg::MAX_SLOTS_DEF,
  parameter int STAMP_BITS = lwbc_pkg::STAMP_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lwbc_pkg::CAP_W-1:0] cfg_data,
  lwbc_req_if.sink                   req,
  lwbc_rsp_if.source                 rsp
);

  logic [lwbc_pkg::CAP_W-1:0] cap_reg;
  logic                       q_valid;
  logic                       q_ready;
  lwbc_pkg::req_t             q_data;

  // hold capacity register
  always_ff @(posedge clk) begin
    if (rst) cap_reg <= '0;
    else if (cfg_we) cap_reg <= cfg_data;
  end

  lwbc_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  lwbc_back #(.MAX_SLOTS(MAX_SLOTS), .STAMP_BITS(STAMP_BITS)) u_back (
    .clk(clk), .rst(rst), .cap_reg(cap_reg),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data), .rsp(rsp)
  );

endmodule

FILE: test/lwbc_tb_if.sv
interface lwbc_tb_cfg_if;
  logic                       we;
  logic [lwbc_pkg::CAP_W-1:0] data;
endinterface

FILE: test/lwbc_tag_checker.sv
module lwbc_tag_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [lwbc_pkg::CAP_W-1:0] cfg_data,
  input  logic req_valid,
  input  logic req_ready,
  input  logic req_type,
  input  logic [lwbc_pkg::CLUSTER_W-1:0] req_cluster,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  lwbc_pkg::rsp_t rsp_item,
  output int   mismatch_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS   = lwbc_pkg::MAX_SLOTS_DEF;
  localparam int STAMP_W = lwbc_pkg::STAMP_BITS_DEF;

  logic [lwbc_pkg::CLUSTER_W-1:0] tags [SLOTS];
  logic                           dirty [SLOTS];
  logic [STAMP_W-1:0]             stamps [SLOTS];
  int                             fill_count;
  logic [STAMP_W-1:0]             access_ctr;
  int                             capacity;
  lwbc_pkg::rsp_t                 expected_rsps [$];

  // compute the result of one request and update the tag state
  function automatic lwbc_pkg::rsp_t lookup_and_update(logic is_wr,
                                                       logic [lwbc_pkg::CLUSTER_W-1:0] cl);
    lwbc_pkg::rsp_t     r;
    int                 idx;
    int                 cap;
    logic [STAMP_W-1:0] best_age;
    logic [STAMP_W-1:0] age;
    r = '0;
    idx = -1;
    cap = (capacity > SLOTS) ? SLOTS : capacity;
    if (cap == 0) return r;
    access_ctr = access_ctr + STAMP_W'(1);
    for (int i = 0; i < fill_count; i++) begin
      if (idx < 0 && tags[i] == cl) idx = i;
    end
    if (idx >= 0) begin
      r.hit = 1'b1;
      r.slot_valid = 1'b1;
      r.slot = idx[lwbc_pkg::SLOT_W-1:0];
      stamps[idx] = access_ctr;
      if (is_wr) dirty[idx] = 1'b1;
    end else if (is_wr) begin
      if (fill_count >= cap) begin
        // oldest live entry, lowest index on ties
        idx = 0;
        best_age = access_ctr - stamps[0];
        for (int i = 1; i < fill_count; i++) begin
          age = access_ctr - stamps[i];
          if (age > best_age) begin
            idx = i;
            best_age = age;
          end
        end
        if (dirty[idx]) begin
          r.writeback_needed = 1'b1;
          r.evicted_cluster = tags[idx];
        end
      end else begin
        idx = fill_count;
        fill_count++;
      end
      tags[idx] = cl;
      dirty[idx] = 1'b0;
      stamps[idx] = access_ctr;
      r.slot_valid = 1'b1;
      r.slot = idx[lwbc_pkg::SLOT_W-1:0];
    end
    return r;
  endfunction

  // track config, predict on accepted requests, compare accepted results
  always @(posedge clk) begin
    lwbc_pkg::rsp_t exp_r;
    if (rst) begin
      fill_count = 0;
      access_ctr = '0;
      capacity = 0;
      mismatch_count = 0;
      for (int i = 0; i < SLOTS; i++) dirty[i] = 1'b0;
      expected_rsps.delete();
    end else begin
      if (cfg_we) capacity = int'(cfg_data);
      if (req_valid && req_ready)
        expected_rsps.push_back(lookup_and_update(req_type, req_cluster));
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("unexpected result item %p", rsp_item);
        end else begin
          exp_r = expected_rsps.pop_front();
          if (exp_r.hit !== rsp_item.hit || exp_r.slot_valid !== rsp_item.slot_valid ||
              exp_r.slot !== rsp_item.slot ||
              exp_r.writeback_needed !== rsp_item.writeback_needed ||
              exp_r.evicted_cluster !== rsp_item.evicted_cluster) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
              $display("result mismatch: expected %p, got %p", exp_r, rsp_item);
          end
        end
      end
    end
    pending_count = expected_rsps.size();
  end
endmodule

FILE: test/lru_writeback_block_cache_tags_core_tb.sv
module lru_writeback_block_cache_tags_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rsp_ready_r = 1'b0;
  int   mismatch_count;
  int   pending_count;
  int   stall_cycles;
  int   idle_cycles;
  lwbc_pkg::rsp_t rsp_item;
  logic [lwbc_pkg::CLUSTER_W-1:0] hot_set [16];

  lwbc_tb_cfg_if cfg ();
  lwbc_req_if req ();
  lwbc_rsp_if rsp ();

  assign rsp.ready = rsp_ready_r;
  assign rsp_item = '{rsp.hit, rsp.slot_valid, rsp.slot, rsp.writeback_needed,
                      rsp.evicted_cluster};

  always #4 clk = ~clk;

  lru_writeback_block_cache_tags_core u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg.we), .cfg_data(cfg.data), .req(req), .rsp(rsp)
  );

  lwbc_tag_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg.we), .cfg_data(cfg.data),
    .req_valid(req.valid), .req_ready(req.ready), .req_type(req.req_type),
    .req_cluster(req.cluster_number), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_item(rsp_item), .mismatch_count(mismatch_count), .pending_count(pending_count)
  );

  // send one item, after a random gap if allow_gap; valid stays up for the next one
  task automatic send_request(logic is_wr, logic [lwbc_pkg::CLUSTER_W-1:0] cl,
                              bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= is_wr;
    req.cluster_number <= cl;
    do @(posedge clk); while (!req.ready);
  endtask

  // drop valid and wait until every result is back
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // write capacity once all results are back and the block is quiet
  task automatic set_capacity(logic [lwbc_pkg::CAP_W-1:0] cap);
    drain();
    repeat (150) @(posedge clk);
    cfg.we <= 1'b1;
    cfg.data <= cap;
    @(posedge clk);
    cfg.we <= 1'b0;
  endtask

  // random result stalls after accepted items, drawn per item
  always @(posedge clk) begin
    int draw;
    if (rst) begin
      rsp_ready_r <= 1'b0;
      stall_cycles <= 0;
    end else if (rsp.valid && rsp_ready_r) begin
      draw = int'($urandom_range(0, 3));
      rsp_ready_r <= (draw == 0);
      stall_cycles <= (draw == 0) ? 0 : draw - 1;
    end else if (stall_cycles > 0) begin
      stall_cycles <= stall_cycles - 1;
      rsp_ready_r <= 1'b0;
    end else begin
      rsp_ready_r <= 1'b1;
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("lru_writeback_block_cache_tags_core_tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [lwbc_pkg::CAP_W-1:0] caps [6];
    int pool;
    caps = '{7'd1, 7'd4, 7'd64, 7'd127, 7'd3, 7'd16};
    cfg.we = 1'b0;
    cfg.data = '0;
    req.valid = 1'b0;
    req.req_type = lwbc_pkg::REQ_READ;
    req.cluster_number = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled cache
    send_request(lwbc_pkg::REQ_WRITE, 28'h5, 1'b0);
    send_request(lwbc_pkg::REQ_READ, 28'h5, 1'b0);
    // capacity two: fill, hit, dirty eviction, clean eviction, field extremes
    set_capacity(7'd2);
    send_request(lwbc_pkg::REQ_READ, 28'h0, 1'b0);
    send_request(lwbc_pkg::REQ_WRITE, 28'h0, 1'b0);
    send_request(lwbc_pkg::REQ_WRITE, 28'hFFFFFFF, 1'b0);
    send_request(lwbc_pkg::REQ_READ, 28'hFFFFFFF, 1'b0);
    send_request(lwbc_pkg::REQ_WRITE, 28'h0, 1'b0);
    send_request(lwbc_pkg::REQ_WRITE, 28'hAAAAAAA, 1'b0);
    send_request(lwbc_pkg::REQ_WRITE, 28'h5555555, 1'b0);
    send_request(lwbc_pkg::REQ_READ, 28'hAAAAAAA, 1'b0);
    send_request(lwbc_pkg::REQ_WRITE, 28'h1234567, 1'b0);
    // lower capacity below fill count, then disable again
    set_capacity(7'd1);
    send_request(lwbc_pkg::REQ_WRITE, 28'h1234567, 1'b0);
    send_request(lwbc_pkg::REQ_READ, 28'hAAAAAAA, 1'b0);
    send_request(lwbc_pkg::REQ_WRITE, 28'h7777777, 1'b0);
    set_capacity(7'd0);
    send_request(lwbc_pkg::REQ_WRITE, 28'h9, 1'b0);

    // random phases over several capacities
    for (int ph = 0; ph < 6; ph++) begin
      set_capacity(caps[ph]);
      pool = (caps[ph] > 8) ? 80 : 12;
      for (int i = 0; i < 16; i++) hot_set[i] = 28'($urandom);
      for (int n = 0; n < 140; n++) begin
        if ($urandom_range(0, 9) < 8)
          send_request(1'($urandom_range(0, 1)),
                       28'($urandom_range(1, pool)) ^ (hot_set[n % 16] & 28'hFFFFF00),
                       1'b1);
        else
          send_request(1'($urandom_range(0, 1)), 28'($urandom), 1'b1);
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0)
      $display("lru_writeback_block_cache_tags_core_tb: done, clean");
    else
      $display("lru_writeback_block_cache_tags_core_tb: done, errors");
    $finish;
  end
endmodule
